// ===== rtl/sowd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sixth-order weighted derivative block.
// Holds the sequencer states, the stage-enable bundle, register indexes and the
// fixed-point constants shared by the lanes and the top level.
package sowd_pkg;

  localparam int WIN_DEPTH = 6;   // previous points held per combined value
  localparam int HALF      = 3;   // stencil half width
  localparam int POS_W     = 12;  // width of the position fields
  localparam int DIM_W     = 13;  // width of the dimension registers

  localparam logic [DIM_W-1:0] ROW_COUNT_RST    = 13'd64;
  localparam logic [DIM_W-1:0] COLUMN_COUNT_RST = 13'd64;
  localparam logic [31:0]      INV_SPACING_RST  = 32'd65536;

  localparam logic signed [47:0] W48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] W48_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] D_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] D_MIN   = 32'sh8000_0000;

  localparam logic signed [55:0] TAP_NEAR = 56'sd45;
  localparam logic signed [55:0] TAP_MID  = 56'sd9;

  // The quotient by 60 * 2^16 is taken as (sum >> 18) / 15. The divide by 15
  // uses a 2^-39 scaled reciprocal, exact for dividends below 2^35.
  localparam logic [35:0] RECIP_M    = 36'd36650387593;
  localparam logic [45:0] SAT_POS_Y  = 46'd32212254720;  // 15 * 2^31
  localparam logic [45:0] SAT_NEG_Y  = 46'd32212254735;  // 15 * (2^31 + 1)

  typedef enum logic [1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_INV_SPACING  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_STEN,
    ST_MAG,
    ST_PROD,
    ST_SUM,
    ST_DIV,
    ST_QUO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic comb_en;
    logic sten_en;
    logic mag_en;
    logic prod_en;
    logic sum_en;
    logic div_en;
    logic quo_en;
  } ctrl_t;

endpackage

// ===== rtl/sowd_cell.sv =====
`timescale 1ns / 1ps
// One window cell: holds one earlier point of both combined values.
// Uses no package; its shift enable comes from the sequencer in the top level.
module sowd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic signed [47:0] d_first,
  input  logic signed [47:0] d_second,
  output logic signed [47:0] q_first,
  output logic signed [47:0] q_second
);

  logic signed [47:0] first_r;
  logic signed [47:0] second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
    end else if (shift_en) begin
      first_r  <= d_first;
      second_r <= d_second;
    end
  end

  assign q_first  = first_r;
  assign q_second = second_r;

endmodule

// ===== rtl/sowd_lane.sv =====
`timescale 1ns / 1ps
// Arithmetic lane for one combined value: weighted sum, stencil, scaling by the
// inverse spacing, divide by 60 and saturation. Uses sowd_pkg; stages are
// stepped by the enable bundle from the top-level sequencer.
module sowd_lane (
  input  logic               clk,
  input  sowd_pkg::ctrl_t    ctrl,
  input  logic signed [31:0] u_val,
  input  logic signed [31:0] v_val,
  input  logic signed [31:0] wu,
  input  logic signed [31:0] wv,
  input  logic [31:0]        inv_spacing,
  input  logic signed [47:0] tap [sowd_pkg::WIN_DEPTH],
  output logic signed [47:0] comb_val,
  output logic signed [31:0] deriv
);
  import sowd_pkg::*;

  logic signed [63:0] prod_u_r;
  logic signed [63:0] prod_v_r;
  logic signed [47:0] comb_r;
  logic signed [55:0] sten_r;
  logic               neg_r;
  logic [53:0]        mag_r;
  logic [53:0]        ph_r;
  logic [63:0]        pl_r;
  logic               sat_r;
  logic [45:0]        y_r;
  logic [52:0]        pa_r;
  logic [53:0]        pb_r;
  logic [31:0]        q_r;

  logic signed [48:0] comb_sum;
  logic signed [47:0] comb_sat;
  logic signed [48:0] d_near;
  logic signed [48:0] d_mid;
  logic signed [48:0] d_far;
  logic signed [55:0] sten_sum;
  logic [64:0]        tot;
  logic [71:0]        quo_full;

  always_comb begin
    // Each product is floored to Q32.16 before the add.
    comb_sum = 49'(prod_u_r >>> 16) + 49'(prod_v_r >>> 16);
    if (comb_sum[48] != comb_sum[47]) begin
      comb_sat = comb_sum[48] ? W48_MIN : W48_MAX;
    end else begin
      comb_sat = comb_sum[47:0];
    end
  end

  always_comb begin
    d_near   = 49'(tap[4]) - 49'(tap[2]);
    d_mid    = 49'(tap[5]) - 49'(tap[1]);
    d_far    = 49'(comb_r) - 49'(tap[0]);
    sten_sum = 56'(d_near) * TAP_NEAR - 56'(d_mid) * TAP_MID + 56'(d_far);
  end

  assign tot      = {1'b0, ph_r[21:0], 32'b0} + {1'b0, pl_r};
  assign quo_full = (72'(pa_r) << 18) + 72'(pb_r);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_u_r <= 64'(u_val) * 64'(wu);
      prod_v_r <= 64'(v_val) * 64'(wv);
    end
    if (ctrl.comb_en) begin
      comb_r <= comb_sat;
    end
    if (ctrl.sten_en) begin
      sten_r <= sten_sum;
    end
    if (ctrl.mag_en) begin
      neg_r <= sten_r[55];
      mag_r <= sten_r[55] ? 54'(-sten_r) : 54'(sten_r);
    end
    if (ctrl.prod_en) begin
      ph_r <= 54'(mag_r[53:32]) * 54'(inv_spacing);
      pl_r <= 64'(mag_r[31:0]) * 64'(inv_spacing);
    end
    if (ctrl.sum_en) begin
      sat_r <= (|ph_r[53:22]) | tot[64];
      y_r   <= tot[63:18];
    end
    if (ctrl.div_en) begin
      // Past the bound the quotient would exceed the output range.
      sat_r <= sat_r | (y_r >= (neg_r ? SAT_NEG_Y : SAT_POS_Y));
      pa_r  <= 53'(y_r[34:18]) * 53'(RECIP_M);
      pb_r  <= 54'(y_r[17:0]) * 54'(RECIP_M);
    end
    if (ctrl.quo_en) begin
      q_r <= quo_full[70:39];
    end
  end

  assign comb_val = comb_sat;

  always_comb begin
    if (sat_r) begin
      deriv = neg_r ? D_MIN : D_MAX;
    end else begin
      deriv = neg_r ? -$signed(q_r) : $signed(q_r);
    end
  end

endmodule

// ===== rtl/sixth_order_weighted_derivative.sv =====
`timescale 1ns / 1ps
// Sixth-order weighted first derivative along the row index of a streamed grid.
// Input channel: one grid point per request (u, v and four weights), column
// order with the row index fastest. Each point enters the window row of cells;
// the result of the point three rows earlier is sent on the output channel
// when that point lies at least BOUNDARY from every edge, with its row, column
// and a flag on the last interior point of the grid.
// Sequencing: a point that yields no result holds the input through accept,
// multiply, combine and stencil; one that yields a result also through
// magnitude, scale, sum, divide, quotient and output; the steps run one after
// another through each lane's stage registers, and the next point is taken
// only once the steps for the last one are done.
// The output register decouples the channels: the next point is taken while a
// result waits; a stalled receiver holds the result and, once the next result
// is ready, holds the sequencer and with it the input.
// Reset: dimensions return to 64 x 64, inverse spacing to 1.0, the position
// counters and window clear and no result is pending. Configuration writes are
// taken every cycle and belong in idle time between grids.
module sixth_order_weighted_derivative #(
  parameter int MAX_DIM  = 4096,
  parameter int BOUNDARY = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_u_val,
  input  logic [31:0] in_v_val,
  input  logic [31:0] in_weight_u_first,
  input  logic [31:0] in_weight_v_first,
  input  logic [31:0] in_weight_u_second,
  input  logic [31:0] in_weight_v_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_deriv_first,
  output logic [31:0] out_deriv_second,
  output logic [11:0] out_row_pos,
  output logic [11:0] out_col_pos,
  output logic        out_last_point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sowd_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int EFF_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = EFF_W + 6;

  logic [DIM_W-1:0] row_count_r;
  logic [DIM_W-1:0] column_count_r;
  logic [31:0]      inv_spacing_r;

  logic [CNT_W-1:0] rc_r;
  logic [CNT_W-1:0] cc_r;
  logic             emit_r;
  logic             last_r;
  logic [CNT_W-1:0] row_r;
  logic [CNT_W-1:0] col_r;

  logic signed [31:0] u_r;
  logic signed [31:0] v_r;
  logic signed [31:0] wu1_r;
  logic signed [31:0] wv1_r;
  logic signed [31:0] wu2_r;
  logic signed [31:0] wv2_r;

  state_t state_r;
  state_t state_nxt;
  ctrl_t  ctrl;
  logic   load_out;
  logic   in_acc;

  logic [EFF_W-1:0] nr;
  logic [EFF_W-1:0] nc;
  logic [CMP_W-1:0] nr_x;
  logic [CMP_W-1:0] nc_x;
  logic [CMP_W-1:0] rc_x;
  logic [CMP_W-1:0] cc_x;
  logic [CMP_W-1:0] bnd;
  logic [CMP_W-1:0] hw;
  logic [CMP_W-1:0] rc_inc;
  logic [CMP_W-1:0] cc_inc;
  logic             emit_now;
  logic             last_now;

  logic signed [47:0] win_first  [WIN_DEPTH];
  logic signed [47:0] win_second [WIN_DEPTH];
  logic signed [47:0] comb_first;
  logic signed [47:0] comb_second;
  logic signed [31:0] deriv_first;
  logic signed [31:0] deriv_second;

  logic [CNT_W+POS_W-1:0] row_ext;
  logic [CNT_W+POS_W-1:0] col_ext;

  logic              out_valid_r;
  logic [31:0]       out_first_r;
  logic [31:0]       out_second_r;
  logic [POS_W-1:0]  out_row_r;
  logic [POS_W-1:0]  out_col_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
      inv_spacing_r  <= INV_SPACING_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_data[DIM_W-1:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_data[DIM_W-1:0];
        CFG_INV_SPACING:  inv_spacing_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions are the registers clamped to [1, MAX_DIM].
  always_comb begin
    if (row_count_r == '0) begin
      nr = EFF_W'(1);
    end else if (32'(row_count_r) > MAX_DIM) begin
      nr = EFF_W'(MAX_DIM);
    end else begin
      nr = EFF_W'(row_count_r);
    end
    if (column_count_r == '0) begin
      nc = EFF_W'(1);
    end else if (32'(column_count_r) > MAX_DIM) begin
      nc = EFF_W'(MAX_DIM);
    end else begin
      nc = EFF_W'(column_count_r);
    end
  end

  // The arriving point completes the stencil of the point HALF rows back.
  always_comb begin
    nr_x     = CMP_W'(nr);
    nc_x     = CMP_W'(nc);
    rc_x     = CMP_W'(rc_r);
    cc_x     = CMP_W'(cc_r);
    bnd      = CMP_W'(BOUNDARY);
    hw       = CMP_W'(HALF);
    rc_inc   = rc_x + CMP_W'(1);
    cc_inc   = cc_x + CMP_W'(1);
    emit_now = (rc_x >= bnd + hw) && (rc_x + bnd < nr_x + hw) &&
               (cc_x >= bnd) && (cc_x + bnd < nc_x);
    last_now = (rc_x + bnd + CMP_W'(1) == nr_x + hw) &&
               (cc_x + bnd + CMP_W'(1) == nc_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= '0;
      cc_r   <= '0;
      emit_r <= 1'b0;
    end else if (in_acc) begin
      emit_r <= emit_now;
      if (rc_inc >= nr_x) begin
        rc_r <= '0;
        cc_r <= (cc_inc >= nc_x) ? '0 : CNT_W'(cc_inc);
      end else begin
        rc_r <= CNT_W'(rc_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= last_now;
      row_r  <= rc_r - CNT_W'(HALF);
      col_r  <= cc_r;
      u_r    <= in_u_val;
      v_r    <= in_v_val;
      wu1_r  <= in_weight_u_first;
      wv1_r  <= in_weight_v_first;
      wu2_r  <= in_weight_u_second;
      wv2_r  <= in_weight_v_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_COMB;
      end
      ST_COMB: begin
        ctrl.comb_en = 1'b1;
        state_nxt    = ST_STEN;
      end
      ST_STEN: begin
        ctrl.sten_en = 1'b1;
        state_nxt    = emit_r ? ST_MAG : ST_IDLE;
      end
      ST_MAG: begin
        ctrl.mag_en = 1'b1;
        state_nxt   = ST_PROD;
      end
      ST_PROD: begin
        ctrl.prod_en = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        ctrl.sum_en = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div_en = 1'b1;
        state_nxt   = ST_QUO;
      end
      ST_QUO: begin
        ctrl.quo_en = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Window row: the newest combined value enters the top cell and every cell
  // passes its value down when the stencil step runs.
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    if (i == WIN_DEPTH - 1) begin : g_head
      sowd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctrl.sten_en),
        .d_first  (comb_first),
        .d_second (comb_second),
        .q_first  (win_first[i]),
        .q_second (win_second[i])
      );
    end else begin : g_body
      sowd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctrl.sten_en),
        .d_first  (win_first[i+1]),
        .d_second (win_second[i+1]),
        .q_first  (win_first[i]),
        .q_second (win_second[i])
      );
    end
  end

  sowd_lane u_lane_first (
    .clk         (clk),
    .ctrl        (ctrl),
    .u_val       (u_r),
    .v_val       (v_r),
    .wu          (wu1_r),
    .wv          (wv1_r),
    .inv_spacing (inv_spacing_r),
    .tap         (win_first),
    .comb_val    (comb_first),
    .deriv       (deriv_first)
  );

  sowd_lane u_lane_second (
    .clk         (clk),
    .ctrl        (ctrl),
    .u_val       (u_r),
    .v_val       (v_r),
    .wu          (wu2_r),
    .wv          (wv2_r),
    .inv_spacing (inv_spacing_r),
    .tap         (win_second),
    .comb_val    (comb_second),
    .deriv       (deriv_second)
  );

  assign row_ext = {{POS_W{1'b0}}, row_r};
  assign col_ext = {{POS_W{1'b0}}, col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_first_r  <= deriv_first;
      out_second_r <= deriv_second;
      out_row_r    <= row_ext[POS_W-1:0];
      out_col_r    <= col_ext[POS_W-1:0];
      out_last_r   <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_deriv_first  = out_first_r;
  assign out_deriv_second = out_second_r;
  assign out_row_pos      = out_row_r;
  assign out_col_pos      = out_col_r;
  assign out_last_point   = out_last_r;

endmodule

// ===== rtl/sowd_check.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sixth-order weighted derivative block, attached
// to the top level by the bind statement at the end of this file.
module sowd_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_deriv_first,
  input logic [31:0] out_deriv_second,
  input logic [11:0] out_row_pos,
  input logic [11:0] out_col_pos,
  input logic        out_last_point
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A request keeps the sequencer busy through multiply, combine and stencil.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too early");

  // A new result is only loaded while an item is being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_deriv_first) &&
    $stable(out_deriv_second) && $stable(out_row_pos) &&
    $stable(out_col_pos) && $stable(out_last_point))
    else $error("stalled result changed");

endmodule

bind sixth_order_weighted_derivative sowd_check u_sowd_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_deriv_first  (out_deriv_first),
  .out_deriv_second (out_deriv_second),
  .out_row_pos      (out_row_pos),
  .out_col_pos      (out_col_pos),
  .out_last_point   (out_last_point)
);
